### rtl/bmhq_pkg.sv
// Shared types and defaults for the binary min-heap queue.
// No dependencies; imported by bmhq_seq, binary_min_heap_queue_core and bmhq_chk.
package bmhq_pkg;

  // Parameter defaults
  localparam int unsigned CapacityDef   = 1024;
  localparam int unsigned KeyBitsDef    = 32;
  localparam int unsigned HandleBitsDef = 16;

  // Request command codes
  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_EXTRACT = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Result handshake from the sequencer to the output stage
  typedef struct packed {
    logic    valid;
    status_e status;
  } res_ctl_t;

endpackage

### rtl/bmhq_ram.sv
// Heap entry storage: one write port, two read ports, registered read data.
// Depends on nothing; contents are undefined until written.
module bmhq_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = 10,
  parameter int unsigned DataW = 48
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [DataW-1:0] rdata_a_o,
  output logic [DataW-1:0] rdata_b_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rdata_a_q;
  logic [DataW-1:0] rdata_b_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read ports, registered read data
  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### rtl/bmhq_seq.sv
// Heap sequencer: runs insert sift-up and extract sift-down over the entry RAM.
// Depends on bmhq_pkg and bmhq_ram.
module bmhq_seq #(
  parameter int unsigned Capacity   = bmhq_pkg::CapacityDef,
  parameter int unsigned KeyBits    = bmhq_pkg::KeyBitsDef,
  parameter int unsigned HandleBits = bmhq_pkg::HandleBitsDef,
  parameter int unsigned AddrW      = $clog2(Capacity),
  parameter int unsigned CountW     = $clog2(Capacity + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   ready_o,
  input  logic [1:0]             command_i,
  input  logic [KeyBits-1:0]     key_i,
  input  logic [HandleBits-1:0]  handle_i,
  output bmhq_pkg::res_ctl_t     res_o,
  input  logic                   res_ready_i,
  output logic [KeyBits-1:0]     res_key_o,
  output logic [HandleBits-1:0]  res_handle_o,
  output logic [CountW-1:0]      res_count_o
);
  import bmhq_pkg::*;

  localparam int unsigned DataW = KeyBits + HandleBits;
  localparam int unsigned IdxW  = AddrW + 2;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UP   = 3'd1;
  localparam logic [2:0] S_EXLD = 3'd2;
  localparam logic [2:0] S_DN   = 3'd3;
  localparam logic [2:0] S_WRE  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [CountW-1:0]     count_q, count_d;
  logic [AddrW-1:0]      pos_q, pos_d;
  logic [DataW-1:0]      ent_q, ent_d;
  logic [KeyBits-1:0]    res_key_q, res_key_d;
  logic [HandleBits-1:0] res_handle_q, res_handle_d;
  status_e               res_status_q, res_status_d;

  logic                  we;
  logic [AddrW-1:0]      waddr, raddr_a, raddr_b;
  logic [DataW-1:0]      wdata, rdata_a, rdata_b;

  logic [KeyBits-1:0]    ent_key, rd_a_key, rd_b_key;
  logic [AddrW-1:0]      par_idx;
  logic [IdxW-1:0]       cnt_ext, left_l, right_l, nl_l, nr_l;
  logic                  right_ok, pick_right;
  logic [DataW-1:0]      pk_ent;
  logic [AddrW-1:0]      pk_idx;

  bmhq_ram #(
    .Depth(Capacity),
    .AddrW(AddrW),
    .DataW(DataW)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  // Entry fields and tree index arithmetic
  assign ent_key  = ent_q[DataW-1 -: KeyBits];
  assign rd_a_key = rdata_a[DataW-1 -: KeyBits];
  assign rd_b_key = rdata_b[DataW-1 -: KeyBits];
  assign par_idx  = (pos_q - AddrW'(1)) >> 1;
  assign cnt_ext  = IdxW'(count_q);
  assign left_l   = IdxW'({pos_q, 1'b1});
  assign right_l  = left_l + IdxW'(1);
  assign right_ok = right_l < cnt_ext;

  // Smaller child; left wins on equal keys
  assign pick_right = right_ok && (rd_b_key < rd_a_key);
  assign pk_ent     = pick_right ? rdata_b : rdata_a;
  assign pk_idx     = pick_right ? AddrW'(right_l) : AddrW'(left_l);
  assign nl_l       = IdxW'({pk_idx, 1'b1});
  assign nr_l       = nl_l + IdxW'(1);

  // Next state and memory port control
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    pos_d        = pos_q;
    ent_d        = ent_q;
    res_key_d    = res_key_q;
    res_handle_d = res_handle_q;
    res_status_d = res_status_q;
    we           = 1'b0;
    waddr        = pos_q;
    wdata        = ent_q;
    raddr_a      = '0;
    raddr_b      = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          res_status_d = ST_OK;
          res_key_d    = '0;
          res_handle_d = '0;
          state_d      = S_DONE;
          case (cmd_e'(command_i))
            CMD_INSERT: begin
              if (count_q == CountW'(Capacity)) begin
                res_status_d = ST_FULL;
              end else begin
                ent_d   = {key_i, handle_i};
                pos_d   = AddrW'(count_q);
                count_d = count_q + CountW'(1);
                if (count_q == '0) begin
                  // First entry goes straight to the root
                  we    = 1'b1;
                  waddr = '0;
                  wdata = {key_i, handle_i};
                end else begin
                  raddr_a = (AddrW'(count_q) - AddrW'(1)) >> 1;
                  state_d = S_UP;
                end
              end
            end
            CMD_EXTRACT: begin
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
              end else begin
                raddr_a = '0;
                raddr_b = AddrW'(count_q - CountW'(1));
                count_d = count_q - CountW'(1);
                state_d = S_EXLD;
              end
            end
            CMD_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // Sift-up: parent moves down into the hole while its key is greater
      S_UP: begin
        we = 1'b1;
        if (rd_a_key > ent_key) begin
          wdata = rdata_a;
          pos_d = par_idx;
          if (par_idx == '0) begin
            state_d = S_WRE;
          end else begin
            raddr_a = (par_idx - AddrW'(1)) >> 1;
          end
        end else begin
          state_d = S_DONE;
        end
      end

      // Root and last entry arrive; last entry becomes the sinking entry
      S_EXLD: begin
        res_key_d    = rd_a_key;
        res_handle_d = rdata_a[HandleBits-1:0];
        ent_d        = rdata_b;
        pos_d        = '0;
        if (count_q == '0) begin
          state_d = S_DONE;
        end else if (count_q == CountW'(1)) begin
          state_d = S_WRE;
        end else begin
          raddr_a = AddrW'(1);
          raddr_b = (count_q > CountW'(2)) ? AddrW'(2) : AddrW'(1);
          state_d = S_DN;
        end
      end

      // Sift-down: smaller child moves up while the sinking key is greater.
      // Child reads never hit the entry written this cycle (children > pos).
      S_DN: begin
        we = 1'b1;
        if (ent_key > pk_ent[DataW-1 -: KeyBits]) begin
          wdata = pk_ent;
          pos_d = pk_idx;
          if (nl_l < cnt_ext) begin
            raddr_a = AddrW'(nl_l);
            raddr_b = (nr_l < cnt_ext) ? AddrW'(nr_l) : AddrW'(nl_l);
          end else begin
            state_d = S_WRE;
          end
        end else begin
          state_d = S_DONE;
        end
      end

      S_WRE: begin
        we      = 1'b1;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Working entry and result payload
  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    ent_q        <= ent_d;
    res_key_q    <= res_key_d;
    res_handle_q <= res_handle_d;
    res_status_q <= res_status_d;
  end

  assign ready_o       = (state_q == S_IDLE);
  assign res_o.valid   = (state_q == S_DONE);
  assign res_o.status  = res_status_q;
  assign res_key_o     = res_key_q;
  assign res_handle_o  = res_handle_q;
  assign res_count_o   = count_q;

endmodule

### rtl/binary_min_heap_queue_core.sv
// Binary min-heap priority queue: top level with the result register.
// Depends on bmhq_pkg, bmhq_seq and bmhq_ram.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------
//   request  | in_valid_i / in_ready_o | command_i, key_i, node_handle_i
//   result   | out_valid_o/ out_ready_i| status_o, out_key_o, out_handle_o,
//            |                        | entry_count_o
//
// One request at a time. An insert sifts the new entry up (into an empty heap it
// goes straight to the root) and an extract sifts the last entry down (none when
// it takes the last entry); the entry moves at most log2(CAPACITY) heap levels
// and each level is one read-compare-write turn of the two-read-port entry RAM.
// Clear, drops and empty extracts go straight to the result. Reset empties the
// heap at once. A held result stalls the next request only at its completion.
module binary_min_heap_queue_core #(
  parameter int unsigned CAPACITY    = bmhq_pkg::CapacityDef,
  parameter int unsigned HANDLE_BITS = bmhq_pkg::HandleBitsDef,
  parameter int unsigned KEY_BITS    = bmhq_pkg::KeyBitsDef,
  parameter int unsigned CountW      = $clog2(CAPACITY + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             command_i,
  input  logic [KEY_BITS-1:0]    key_i,
  input  logic [HANDLE_BITS-1:0] node_handle_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             status_o,
  output logic [KEY_BITS-1:0]    out_key_o,
  output logic [HANDLE_BITS-1:0] out_handle_o,
  output logic [CountW-1:0]      entry_count_o
);
  import bmhq_pkg::*;

  localparam int unsigned AddrW = $clog2(CAPACITY);

  res_ctl_t               res;
  logic                   res_ready;
  logic [KEY_BITS-1:0]    res_key;
  logic [HANDLE_BITS-1:0] res_handle;
  logic [CountW-1:0]      res_count;

  logic                   out_valid_q, out_valid_d;
  logic [1:0]             status_q;
  logic [KEY_BITS-1:0]    key_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic [CountW-1:0]      count_q;

  bmhq_seq #(
    .Capacity  (CAPACITY),
    .KeyBits   (KEY_BITS),
    .HandleBits(HANDLE_BITS),
    .AddrW     (AddrW),
    .CountW    (CountW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i),
    .ready_o     (in_ready_o),
    .command_i   (command_i),
    .key_i       (key_i),
    .handle_i    (node_handle_i),
    .res_o       (res),
    .res_ready_i (res_ready),
    .res_key_o   (res_key),
    .res_handle_o(res_handle),
    .res_count_o (res_count)
  );

  // Result register: refill as soon as the held result is taken
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      status_q <= res.status;
      key_q    <= res_key;
      handle_q <= res_handle;
      count_q  <= res_count;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign out_key_o     = key_q;
  assign out_handle_o  = handle_q;
  assign entry_count_o = count_q;

endmodule

### rtl/bmhq_chk.sv
// Port-level checks for the binary min-heap queue, bound to the top level.
// Depends on bmhq_pkg and binary_min_heap_queue_core.
module bmhq_chk #(
  parameter int unsigned CAPACITY    = bmhq_pkg::CapacityDef,
  parameter int unsigned HANDLE_BITS = bmhq_pkg::HandleBitsDef,
  parameter int unsigned KEY_BITS    = bmhq_pkg::KeyBitsDef,
  parameter int unsigned CountW      = $clog2(CAPACITY + 1)
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [1:0]             status_o,
  input logic [KEY_BITS-1:0]    out_key_o,
  input logic [HANDLE_BITS-1:0] out_handle_o,
  input logic [CountW-1:0]      entry_count_o
);
  import bmhq_pkg::*;

  // Held result does not change while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(out_key_o) && $stable(out_handle_o) && $stable(entry_count_o))
    else $error("result changed while stalled");

  // One request in flight: a request is never taken in back-to-back cycles
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while previous one in flight");

  // Empty extract reports an empty heap
  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> entry_count_o == '0)
    else $error("empty status with nonzero count");

  // Dropped insert reports a full heap
  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> entry_count_o == CountW'(CAPACITY))
    else $error("full status with count below capacity");

  // Failed requests carry no entry
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> out_key_o == '0 && out_handle_o == '0)
    else $error("failed request returned an entry");

endmodule

bind binary_min_heap_queue_core bmhq_chk #(
  .CAPACITY   (CAPACITY),
  .HANDLE_BITS(HANDLE_BITS),
  .KEY_BITS   (KEY_BITS),
  .CountW     (CountW)
) u_bmhq_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .out_key_o    (out_key_o),
  .out_handle_o (out_handle_o),
  .entry_count_o(entry_count_o)
);
